// ----- src/lssc_pkg.sv -----
// ----------------------------------------------------------------------------
// lssc_pkg
// Shared types and constants of the LED step sequencer with crossfade.
// ----------------------------------------------------------------------------
`default_nettype none

package lssc_pkg;

   localparam int CHANNELS      = 7;
   localparam int MAX_STEPS     = 16;
   localparam int PWM_MAX       = 1023;
   localparam int FULL          = 255;
   localparam int FULL_SQ       = 255 * 255;
   localparam int MIN_STEP_TIME = 10;
   localparam int TABLE_DEPTH   = CHANNELS * MAX_STEPS;

   // request commands
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_SET   = 2'd1;
   localparam logic [1:0] CMD_LOAD  = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   // configuration register indexes
   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_MASTER = 3'd1;
   localparam logic [2:0] REG_XFADE  = 3'd2;
   localparam logic [2:0] REG_STIME  = 3'd3;
   localparam logic [2:0] REG_COUNT  = 3'd4;
   localparam logic [2:0] REG_SPARE  = 3'd7;

   // datapath operations
   localparam logic [4:0] OP_IDLE    = 5'd0;
   localparam logic [4:0] OP_LOAD    = 5'd1;
   localparam logic [4:0] OP_MOD     = 5'd2;
   localparam logic [4:0] OP_COMMIT  = 5'd3;
   localparam logic [4:0] OP_PREP    = 5'd4;
   localparam logic [4:0] OP_DIVINIT = 5'd5;
   localparam logic [4:0] OP_DIVSTEP = 5'd6;
   localparam logic [4:0] OP_RDA     = 5'd7;
   localparam logic [4:0] OP_RDB     = 5'd8;
   localparam logic [4:0] OP_MUL     = 5'd9;
   localparam logic [4:0] OP_LVL     = 5'd10;
   localparam logic [4:0] OP_DMUL    = 5'd11;
   localparam logic [4:0] OP_DY      = 5'd12;
   localparam logic [4:0] OP_DQ      = 5'd13;
   localparam logic [4:0] OP_DR      = 5'd14;
   localparam logic [4:0] OP_FIX     = 5'd15;
   localparam logic [4:0] OP_DSTORE  = 5'd16;
   localparam logic [4:0] OP_OUT     = 5'd17;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] channel;
      logic [3:0] step_slot;
      logic [7:0] level_value;
   } req_type;

   typedef struct packed {
      logic [9:0] duty_0;
      logic [9:0] duty_1;
      logic [9:0] duty_2;
      logic [9:0] duty_3;
      logic [9:0] duty_4;
      logic [9:0] duty_5;
      logic [9:0] duty_6;
      logic [3:0] current_step;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
      logic [2:0] ch;
   } ctrl_cmd_type;

   typedef struct packed {
      logic prog;
      logic mod_lt;
      logic fade;
      logic fix_lt;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- src/lssc_dp.sv -----
// ----------------------------------------------------------------------------
// lssc_dp
// Datapath: configuration, step state, table memory, crossfade divider,
// per-channel level and duty arithmetic, response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_dp
   import lssc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   input  wire logic [2:0]    csr_index,
   input  wire logic [15:0]   csr_data,
   input  wire req_type       req_data,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      st,
   output rsp_type            rsp_data
);

   logic        mode_ff;
   logic [7:0]  master_ff;
   logic [7:0]  xfade_ff;
   logic [15:0] stime_ff;
   logic [4:0]  count_ff;

   logic [7:0]  lamp_ff [CHANNELS];
   logic [9:0]  duty_ff [CHANNELS];
   logic [7:0]  mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] vld_ff;
   logic [7:0]  mem_rd_ff;
   logic        vld_rd_ff;

   logic [3:0]  si_ff;
   logic [15:0] phase_ff;
   logic [4:0]  v_ff;
   logic        do_mod_ff;
   logic [3:0]  cur_ff;
   logic [3:0]  nxt_ff;
   logic [23:0] t255_ff;
   logic [23:0] ct_ff;
   logic [23:0] den_ff;
   logic [31:0] num_ff;
   logic [24:0] rem_ff;
   logic [7:0]  ta_ff;
   logic [15:0] pa_ff;
   logic [15:0] pb_ff;
   logic [15:0] x_ff;
   logic [25:0] y_ff;
   logic [9:0]  q_ff;
   logic [18:0] r_ff;
   rsp_type     rsp_ff;

   logic [4:0]  n_eff;
   logic [15:0] ph_inc;
   logic        wrap;
   logic [4:0]  v_inc;
   logic [15:0] t_eff;
   logic [23:0] diff;
   logic [24:0] shifted;
   logic [7:0]  b8;
   logic [7:0]  a8;
   logic [6:0]  rd_addr;
   logic [6:0]  wr_addr;
   logic [7:0]  rdata;
   logic [16:0] lvl_sum;
   logic [16:0] lvl_q;
   logic [34:0] y511;
   logic [26:0] q_sum;
   logic [25:0] q_prod;
   logic [25:0] r_full;
   logic        tbl_we;

   always_comb begin
      n_eff = count_ff;
      if (count_ff == 5'd0) begin
         n_eff = 5'd1;
      end else if (count_ff > 5'(MAX_STEPS)) begin
         n_eff = 5'(MAX_STEPS);
      end
   end

   assign ph_inc  = phase_ff + 16'd1;
   assign wrap    = (req_data.command == CMD_TICK) && (ph_inc >= stime_ff);
   assign v_inc   = v_ff + 5'd1;
   assign t_eff   = (phase_ff < stime_ff) ? phase_ff : (stime_ff - 16'd1);
   assign diff    = t255_ff - ct_ff;
   assign shifted = {rem_ff[23:0], num_ff[31]};
   assign b8      = (|num_ff[31:8]) ? 8'(FULL) : num_ff[7:0];
   assign a8      = 8'(FULL) - b8;
   assign rd_addr = {cmd.ch, (cmd.op == OP_RDB) ? nxt_ff : cur_ff};
   assign wr_addr = {req_data.channel, req_data.step_slot};
   assign rdata   = vld_rd_ff ? mem_rd_ff : 8'd0;
   assign lvl_sum = 17'(pa_ff) + 17'(pb_ff);
   // exact divide by 255 for sums up to 255*255
   assign lvl_q   = (lvl_sum + 17'd1 + (lvl_sum >> 8)) >> 8;
   // reciprocal estimate of y / 65025, never above the true quotient
   assign y511    = {y_ff, 9'd0} - 35'(y_ff);
   assign q_sum   = 27'(y_ff) + 27'(y511[34:16]);
   assign q_prod  = {q_ff, 16'd0} - 26'({q_ff, 9'd0}) + 26'(q_ff);
   assign r_full  = y_ff - q_prod;
   assign tbl_we  = (cmd.op == OP_LOAD) && (req_data.command == CMD_LOAD)
                    && (req_data.channel < 3'(CHANNELS));

   assign st.prog   = mode_ff;
   assign st.mod_lt = v_ff < n_eff;
   assign st.fade   = {1'b0, t255_ff} >= ({1'b0, ct_ff} + 25'(stime_ff));
   assign st.fix_lt = r_ff < 19'(FULL_SQ);

   assign rsp_data = rsp_ff;

   // configuration and step state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         master_ff <= 8'd128;
         xfade_ff  <= 8'd50;
         stime_ff  <= 16'd1000;
         count_ff  <= 5'd1;
         si_ff     <= 4'd0;
         phase_ff  <= 16'd0;
         for (int i = 0; i < CHANNELS; i++) begin
            lamp_ff[i] <= 8'(FULL);
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_MODE:   mode_ff   <= csr_data[0];
               REG_MASTER: master_ff <= csr_data[7:0];
               REG_XFADE:  xfade_ff  <= csr_data[7:0];
               REG_STIME:  stime_ff  <= (csr_data < 16'(MIN_STEP_TIME)) ?
                                        16'(MIN_STEP_TIME) : csr_data;
               REG_COUNT:  count_ff  <= csr_data[4:0];
               default: ;
            endcase
         end
         case (cmd.op)
            OP_LOAD: begin
               if (req_data.command == CMD_TICK) begin
                  phase_ff <= wrap ? 16'd0 : ph_inc;
               end
               if ((req_data.command == CMD_SET) && (req_data.channel < 3'(CHANNELS))) begin
                  lamp_ff[req_data.channel] <= req_data.level_value;
               end
            end
            OP_COMMIT: begin
               if (do_mod_ff) begin
                  si_ff <= v_ff[3:0];
               end
            end
            OP_LVL: lamp_ff[cmd.ch] <= lvl_q[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (tbl_we) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         mem[wr_addr] <= req_data.level_value;
      end
      mem_rd_ff <= mem[rd_addr];
      vld_rd_ff <= vld_ff[rd_addr];
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            v_ff      <= {1'b0, si_ff} + {4'd0, wrap};
            do_mod_ff <= mode_ff | wrap;
         end
         OP_MOD: v_ff <= v_ff - n_eff;
         OP_COMMIT: begin
            cur_ff <= v_ff[3:0];
            nxt_ff <= (v_inc == n_eff) ? 4'd0 : v_inc[3:0];
         end
         OP_PREP: begin
            t255_ff <= {t_eff, 8'd0} - 24'(t_eff);
            ct_ff   <= 24'(xfade_ff) * 24'(stime_ff);
            den_ff  <= 24'(8'(FULL) - xfade_ff) * 24'(stime_ff);
         end
         OP_DIVINIT: begin
            num_ff <= st.fade ? ({diff, 8'd0} - 32'(diff)) : 32'd0;
            rem_ff <= 25'd0;
         end
         OP_DIVSTEP: begin
            if (shifted >= {1'b0, den_ff}) begin
               rem_ff <= shifted - {1'b0, den_ff};
               num_ff <= {num_ff[30:0], 1'b1};
            end else begin
               rem_ff <= shifted;
               num_ff <= {num_ff[30:0], 1'b0};
            end
         end
         OP_RDB: ta_ff <= rdata;
         OP_MUL: begin
            pa_ff <= 16'(a8) * 16'(ta_ff);
            pb_ff <= 16'(b8) * 16'(rdata);
         end
         OP_DMUL: x_ff <= 16'(lamp_ff[cmd.ch]) * 16'(master_ff);
         OP_DY:   y_ff <= {x_ff, 10'd0} - 26'(x_ff);
         OP_DQ:   q_ff <= q_sum[25:16];
         OP_DR:   r_ff <= r_full[18:0];
         OP_FIX: begin
            r_ff <= r_ff - 19'(FULL_SQ);
            q_ff <= q_ff + 10'd1;
         end
         OP_DSTORE: duty_ff[cmd.ch] <= q_ff;
         OP_OUT: begin
            rsp_ff.duty_0       <= duty_ff[0];
            rsp_ff.duty_1       <= duty_ff[1];
            rsp_ff.duty_2       <= duty_ff[2];
            rsp_ff.duty_3       <= duty_ff[3];
            rsp_ff.duty_4       <= duty_ff[4];
            rsp_ff.duty_5       <= duty_ff[5];
            rsp_ff.duty_6       <= duty_ff[6];
            rsp_ff.current_step <= si_ff;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/lssc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lssc_ctrl
// Controller: sequences one request through step update, crossfade
// division, level and duty loops, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_ctrl
   import lssc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type st,
   output ctrl_cmd_type       cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MOD  = 4'd1;
   localparam logic [3:0] S_PREP = 4'd2;
   localparam logic [3:0] S_CMP  = 4'd3;
   localparam logic [3:0] S_DIV  = 4'd4;
   localparam logic [3:0] S_RDA  = 4'd5;
   localparam logic [3:0] S_RDB  = 4'd6;
   localparam logic [3:0] S_MUL  = 4'd7;
   localparam logic [3:0] S_LVL  = 4'd8;
   localparam logic [3:0] S_DMUL = 4'd9;
   localparam logic [3:0] S_DY   = 4'd10;
   localparam logic [3:0] S_DQ   = 4'd11;
   localparam logic [3:0] S_DR   = 4'd12;
   localparam logic [3:0] S_FIX  = 4'd13;
   localparam logic [3:0] S_OUT  = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [2:0] ch_ff, ch_in;
   logic [4:0] div_ff, div_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       ch_last;

   assign ch_last   = ch_ff == 3'(CHANNELS - 1);
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd.op       = OP_IDLE;
      cmd.ch       = ch_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (st.mod_lt) begin
               cmd.op   = OP_COMMIT;
               state_in = st.prog ? S_PREP : S_DMUL;
            end else begin
               cmd.op = OP_MOD;
            end
         end
         S_PREP: begin
            cmd.op   = OP_PREP;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.op   = OP_DIVINIT;
            div_in   = 5'd0;
            state_in = st.fade ? S_DIV : S_RDA;
         end
         S_DIV: begin
            cmd.op = OP_DIVSTEP;
            div_in = div_ff + 5'd1;
            if (div_ff == 5'd31) begin
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            cmd.op   = OP_RDA;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.op   = OP_RDB;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_LVL;
         end
         S_LVL: begin
            cmd.op = OP_LVL;
            if (ch_last) begin
               ch_in    = 3'd0;
               state_in = S_DMUL;
            end else begin
               ch_in    = ch_ff + 3'd1;
               state_in = S_RDA;
            end
         end
         S_DMUL: begin
            cmd.op   = OP_DMUL;
            state_in = S_DY;
         end
         S_DY: begin
            cmd.op   = OP_DY;
            state_in = S_DQ;
         end
         S_DQ: begin
            cmd.op   = OP_DQ;
            state_in = S_DR;
         end
         S_DR: begin
            cmd.op   = OP_DR;
            state_in = S_FIX;
         end
         S_FIX: begin
            if (st.fix_lt) begin
               cmd.op = OP_DSTORE;
               if (ch_last) begin
                  ch_in    = 3'd0;
                  state_in = S_OUT;
               end else begin
                  ch_in    = ch_ff + 3'd1;
                  state_in = S_DMUL;
               end
            end else begin
               cmd.op = OP_FIX;
            end
         end
         S_OUT: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= 3'd0;
         div_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/led_step_sequencer_crossfade.sv -----
// ----------------------------------------------------------------------------
// led_step_sequencer_crossfade
// Seven-channel light sequencer with step table and crossfade.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one request: a 1 ms tick, a lamp level write or a step
//          table write. One request is processed at a time; req_ready is
//          high while the controller is idle.
//   rsp_*  returns one response per request: seven PWM duties and the
//          current step. The response sits in an output register, so a
//          finished response may wait while the next request is taken.
//   csr_*  writes configuration registers (index 0..4); always ready.
// Sequence: fader mode runs accept, step update, then for each of the 7
//   channels the duty steps (multiply, scale, quotient, remainder, store)
//   with at most one quotient correction each, then output; program mode
//   adds the crossfade (prepare, compare and, when fading, the 32-step
//   quotient loop), plus table reads and level blend per channel. The step
//   modulo loop repeats while the advanced step index is at or above the step count.
// Reset: levels 255, table cleared by per-entry valid bits (no sweep),
//   step 0, phase 0, registers at their defaults.
// A stalled receiver holds the controller at its final state once the
//   output register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module led_step_sequencer_crossfade
   import lssc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type st;

   assign csr_ready = 1'b1;

   lssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   lssc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the LED step sequencer: requests are driven with random gaps,
// duties and step index are predicted per request and compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import lssc_pkg::*;

   class duty_scoreboard;
      bit          prog_mode;
      int unsigned master, xfade, stime, scount;
      bit [7:0]    lamp [CHANNELS];
      bit [7:0]    steps [CHANNELS][MAX_STEPS];
      int unsigned step_idx, phase;
      rsp_type     pending_duties[$];
      int          errors;

      function void clear();
         prog_mode = 0; master = 128; xfade = 50; stime = 1000; scount = 1;
         foreach (lamp[i]) lamp[i] = 8'd255;
         foreach (steps[i, j]) steps[i][j] = 8'd0;
         step_idx = 0; phase = 0;
         pending_duties.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            REG_MODE:   prog_mode = val[0];
            REG_MASTER: master = val[7:0];
            REG_XFADE:  xfade = val[7:0];
            REG_STIME:  stime = (val < MIN_STEP_TIME) ? MIN_STEP_TIME : val;
            REG_COUNT:  scount = val[4:0];
            default: ;
         endcase
      endfunction

      function int unsigned used_steps();
         if (scount < 1) return 1;
         if (scount > MAX_STEPS) return MAX_STEPS;
         return scount;
      endfunction

      function void fade_levels();
         int unsigned n, t, cur, nxt, a;
         longint unsigned b, num;
         n = used_steps();
         t = (phase < stime) ? phase : stime - 1;
         cur = step_idx % n;
         nxt = (cur + 1) % n;
         step_idx = cur;
         b = 0;
         if ((FULL * t) / stime > xfade) begin
            num = 64'(FULL) * (64'(FULL) * t - 64'(xfade) * stime);
            b = num / (FULL - xfade) / stime;
            if (b > FULL) b = FULL;
         end
         a = FULL - int'(b);
         for (int ch = 0; ch < CHANNELS; ch++)
            lamp[ch] = 8'((64'(a) * steps[ch][cur] + b * steps[ch][nxt]) / FULL);
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         logic [9:0] d [7];
         case (r.command)
            CMD_TICK: begin
               phase = (phase + 1) & 16'hffff;
               if (phase >= stime) begin
                  phase = 0;
                  step_idx = (step_idx + 1) % used_steps();
               end
            end
            CMD_SET:  if (r.channel < CHANNELS) lamp[r.channel] = r.level_value;
            CMD_LOAD: if (r.channel < CHANNELS)
               steps[r.channel][r.step_slot] = r.level_value;
            default: ;
         endcase
         if (prog_mode) fade_levels();
         for (int i = 0; i < 7; i++)
            d[i] = (i < CHANNELS) ? 10'(64'(lamp[i]) * master * PWM_MAX / FULL_SQ) : 10'd0;
         e = '{d[0], d[1], d[2], d[3], d[4], d[5], d[6], 4'(step_idx)};
         pending_duties.push_back(e);
      endfunction

      function void report(string what, int got, int want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endfunction

      function void check_response(rsp_type r);
         rsp_type e;
         if (pending_duties.size() == 0) begin
            report("unexpected response", 0, 0);
            return;
         end
         e = pending_duties.pop_front();
         if (r.duty_0 != e.duty_0) report("duty_0", r.duty_0, e.duty_0);
         if (r.duty_1 != e.duty_1) report("duty_1", r.duty_1, e.duty_1);
         if (r.duty_2 != e.duty_2) report("duty_2", r.duty_2, e.duty_2);
         if (r.duty_3 != e.duty_3) report("duty_3", r.duty_3, e.duty_3);
         if (r.duty_4 != e.duty_4) report("duty_4", r.duty_4, e.duty_4);
         if (r.duty_5 != e.duty_5) report("duty_5", r.duty_5, e.duty_5);
         if (r.duty_6 != e.duty_6) report("duty_6", r.duty_6, e.duty_6);
         if (r.current_step != e.current_step)
            report("current_step", r.current_step, e.current_step);
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready, rsp_valid, rsp_ready;
   req_type     req_data;
   rsp_type     rsp_data;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   duty_scoreboard sb;
   int          cycles;
   bit          hold_off;

   led_step_sequencer_crossfade u_dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // timeout
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 900000) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // receiver with random stalls; a long hold-off when requested
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off) rsp_ready <= 0;
         else if ($urandom_range(0, 9) < 7) rsp_ready <= 1;
         else if ($urandom_range(0, 9) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(10, 60)) @(negedge clock);
         end else rsp_ready <= 0;
      end
   end

   // a nonzero gap, so valid is never dropped and raised at one edge
   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) :
          ($urandom_range(0, 2) == 0 ? 1 : $urandom_range(2, 5));
      repeat (g) @(negedge clock);
   endtask

   task automatic send_request(logic [1:0] cmd, logic [2:0] ch, logic [3:0] slot,
                               logic [7:0] val);
      req_data  <= '{cmd, ch, slot, val};
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid <= 0;
      idle_gap();
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending_duties.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic random_request();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) send_request(CMD_TICK, 3'($urandom), 4'($urandom), 8'($urandom));
      else if (k < 72) send_request(CMD_SET, 3'($urandom), 4'($urandom), 8'($urandom));
      else if (k < 95) send_request(CMD_LOAD, 3'($urandom), 4'($urandom), 8'($urandom));
      else send_request(CMD_SPARE, 3'($urandom), 4'($urandom), 8'($urandom));
   endtask

   task automatic random_phase(int n);
      write_reg(REG_MODE, 16'($urandom_range(0, 1)));
      write_reg(REG_MASTER, ($urandom_range(0, 3) == 0) ? 16'd255 : 16'($urandom));
      write_reg(REG_XFADE, ($urandom_range(0, 4) == 0) ? 16'd255 : 16'($urandom_range(0, 254)));
      write_reg(REG_STIME, 16'($urandom_range(0, 40)));
      write_reg(REG_COUNT, 16'($urandom_range(0, 31)));
      repeat (n) random_request();
      drain();
   endtask

   initial begin
      sb = new();
      sb.clear();
      hold_off = 0;
      req_valid = 0; req_data = '0;
      csr_valid = 0; csr_index = '0; csr_data = '0;
      reset = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: defaults, extremes, every command, ignored channel
      send_request(CMD_TICK, 3'd0, 4'd0, 8'd0);
      send_request(CMD_SET, 3'd0, 4'd0, 8'd0);
      send_request(CMD_SET, 3'd6, 4'd15, 8'd255);
      send_request(CMD_SET, 3'd7, 4'd0, 8'd1);
      send_request(CMD_LOAD, 3'd7, 4'd15, 8'd200);
      send_request(CMD_SPARE, 3'd5, 4'd5, 8'd170);
      drain();
      write_reg(REG_MASTER, 16'd255);
      write_reg(REG_STIME, 16'd3);
      write_reg(REG_COUNT, 16'd0);
      write_reg(REG_XFADE, 16'd0);
      write_reg(REG_SPARE, 16'hffff);
      write_reg(REG_MODE, 16'd1);
      for (int s = 0; s < 2; s++)
         for (int c = 0; c < 7; c++)
            if (c % 3 == 0) send_request(CMD_LOAD, 3'(c), 4'(s), s ? 8'd255 : 8'd0);
      send_request(CMD_SET, 3'd2, 4'd0, 8'd99);
      repeat (11) send_request(CMD_TICK, 3'd0, 4'd0, 8'd0);
      drain();
      // phase beyond step time after shrinking it
      write_reg(REG_COUNT, 16'd16);
      write_reg(REG_STIME, 16'd65535);
      repeat (30) send_request(CMD_TICK, 3'd0, 4'd0, 8'd0);
      drain();
      write_reg(REG_STIME, 16'd10);
      write_reg(REG_COUNT, 16'd31);
      send_request(CMD_TICK, 3'd0, 4'd0, 8'd0);
      drain();

      // receiver holds off while requests keep coming
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         repeat (12) send_request(CMD_TICK, 3'd0, 4'd0, 8'd0);
      join
      drain();

      for (int p = 0; p < 10; p++) random_phase(70);
      write_reg(REG_MASTER, 16'd0);
      random_phase(20);

      if (sb.errors == 0 && sb.pending_duties.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
